FILE: rtl/core/tfn_pkg.sv
package tfn_pkg;

    // Default field widths of the vertex coordinates and of the normal fraction.
    localparam int COORD_WIDTH_DEF      = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    // Fixed width of the result fields, and the counts of axes and of vertex coordinates.
    localparam int OUT_W     = 16;
    localparam int NUM_AXES  = 3;
    localparam int NUM_VERTS = 9;

    // Control that travels beside the data through the root stages.
    typedef struct packed {
        logic valid;
        logic degen;
    } tfn_ctl_t;

endpackage

FILE: rtl/core/tfn_cross.sv
module tfn_cross #(
    parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            en,
    input  logic                                            in_valid,
    input  logic [tfn_pkg::NUM_VERTS-1:0][COORD_WIDTH-1:0]  coord,
    output logic                                            out_valid,
    output logic [tfn_pkg::NUM_AXES-1:0][2*COORD_WIDTH+2:0] n_out
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int NW = PW + 1;

    logic              valid_reg [3];
    logic signed [DW-1:0] ab_reg [3];
    logic signed [DW-1:0] bc_reg [3];
    logic signed [PW-1:0] p_reg  [6];
    logic [NW-1:0]        n_reg  [3];

    // Edge vectors ab = b - a and bc = c - b, one bit wider than a coordinate.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                ab_reg[k] <= $signed({coord[3+k][COORD_WIDTH-1], coord[3+k]})
                           - $signed({coord[k][COORD_WIDTH-1], coord[k]});
                bc_reg[k] <= $signed({coord[6+k][COORD_WIDTH-1], coord[6+k]})
                           - $signed({coord[3+k][COORD_WIDTH-1], coord[3+k]});
            end
        end
    end

    // The six products of the cross product, each on its own multiplier.
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= ab_reg[2] * bc_reg[1];
            p_reg[1] <= ab_reg[1] * bc_reg[2];
            p_reg[2] <= ab_reg[0] * bc_reg[2];
            p_reg[3] <= ab_reg[2] * bc_reg[0];
            p_reg[4] <= ab_reg[1] * bc_reg[0];
            p_reg[5] <= ab_reg[0] * bc_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                n_reg[k] <= {p_reg[2*k][PW-1], p_reg[2*k]}
                          - {p_reg[2*k+1][PW-1], p_reg[2*k+1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < 3; s++) valid_reg[s] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
            valid_reg[1] <= valid_reg[0];
            valid_reg[2] <= valid_reg[1];
        end
    end

    assign out_valid = valid_reg[2];
    always_comb begin
        for (int k = 0; k < 3; k++) n_out[k] = n_reg[k];
    end

endmodule

FILE: rtl/core/tfn_norm_sq.sv
module tfn_norm_sq #(
    parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  logic                                                en,
    input  logic                                                in_valid,
    input  logic [tfn_pkg::NUM_AXES-1:0][2*COORD_WIDTH+2:0]     n_in,
    output logic                                                out_valid,
    output logic [tfn_pkg::NUM_AXES-1:0]                        neg_out,
    output logic [tfn_pkg::NUM_AXES-1:0][4*COORD_WIDTH+5:0]     sq_out,
    output logic [4*COORD_WIDTH+7:0]                            sum_out
);

    localparam int NW   = 2 * COORD_WIDTH + 3;
    localparam int MW   = NW;
    localparam int LO   = MW / 2;
    localparam int HI   = MW - LO;
    localparam int SQW  = 2 * MW;
    localparam int SUMW = SQW + 2;

    logic            valid_reg [4];
    logic [2:0]      neg_reg   [4];
    logic [MW-1:0]   mag_reg   [3];
    logic [2*HI-1:0] hh_reg    [3];
    logic [HI+LO-1:0] hl_reg   [3];
    logic [2*LO-1:0] ll_reg    [3];
    logic [SQW-1:0]  sq_reg    [3];
    logic [SQW-1:0]  sqd_reg   [3];
    logic [SUMW-1:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                neg_reg[0][k] <= n_in[k][NW-1];
                mag_reg[k]    <= n_in[k][NW-1] ? (~n_in[k] + 1'b1) : n_in[k];
            end
            neg_reg[1] <= neg_reg[0];
            neg_reg[2] <= neg_reg[1];
            neg_reg[3] <= neg_reg[2];
        end
    end

    // The square of each magnitude is split into three half-width products.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                hh_reg[k] <= mag_reg[k][MW-1:LO] * mag_reg[k][MW-1:LO];
                hl_reg[k] <= mag_reg[k][MW-1:LO] * mag_reg[k][LO-1:0];
                ll_reg[k] <= mag_reg[k][LO-1:0] * mag_reg[k][LO-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                sq_reg[k]  <= (SQW'(hh_reg[k]) << (2 * LO))
                            + (SQW'(hl_reg[k]) << (LO + 1))
                            + SQW'(ll_reg[k]);
                sqd_reg[k] <= sq_reg[k];
            end
            sum_reg <= SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < 4; s++) valid_reg[s] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
            valid_reg[1] <= valid_reg[0];
            valid_reg[2] <= valid_reg[1];
            valid_reg[3] <= valid_reg[2];
        end
    end

    assign out_valid = valid_reg[3];
    assign neg_out   = neg_reg[3];
    assign sum_out   = sum_reg;
    always_comb begin
        for (int k = 0; k < 3; k++) sq_out[k] = sqd_reg[k];
    end

endmodule

FILE: rtl/core/tfn_digit.sv
module tfn_digit #(
    parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF,
    parameter int BIT              = 0
) (
    input  logic                                                            aclk,
    input  logic                                                            aresetn,
    input  logic                                                            en,
    input  tfn_pkg::tfn_ctl_t                                               ctl_in,
    input  logic [4*COORD_WIDTH+7:0]                                        sum_in,
    input  logic [tfn_pkg::NUM_AXES-1:0]                                    neg_in,
    input  logic [tfn_pkg::NUM_AXES-1:0][4*COORD_WIDTH+2*NORMAL_FRAC_BITS+9:0] e_in,
    input  logic [tfn_pkg::NUM_AXES-1:0][4*COORD_WIDTH+NORMAL_FRAC_BITS+9:0]   t_in,
    input  logic [tfn_pkg::NUM_AXES-1:0][NORMAL_FRAC_BITS+1:0]             j_in,
    output tfn_pkg::tfn_ctl_t                                               ctl_out,
    output logic [4*COORD_WIDTH+7:0]                                        sum_out,
    output logic [tfn_pkg::NUM_AXES-1:0]                                    neg_out,
    output logic [tfn_pkg::NUM_AXES-1:0][4*COORD_WIDTH+2*NORMAL_FRAC_BITS+9:0] e_out,
    output logic [tfn_pkg::NUM_AXES-1:0][4*COORD_WIDTH+NORMAL_FRAC_BITS+9:0]   t_out,
    output logic [tfn_pkg::NUM_AXES-1:0][NORMAL_FRAC_BITS+1:0]             j_out
);

    localparam int SUMW = 4 * COORD_WIDTH + 8;
    localparam int EW   = SUMW + 2 * NORMAL_FRAC_BITS + 2;
    localparam int TW   = SUMW + NORMAL_FRAC_BITS + 2;
    localparam int JW   = NORMAL_FRAC_BITS + 2;
    localparam int DLW  = EW + 3;

    logic              valid_reg;
    logic              degen_reg;
    logic [SUMW-1:0]   sum_reg;
    logic [2:0]        neg_reg;
    logic [2:0][EW-1:0] e_reg;
    logic [2:0][TW-1:0] t_reg;
    logic [2:0][JW-1:0] j_reg;
    logic [DLW-1:0]    delta [3];
    logic [2:0]        take;

    // Setting this bit of j grows j*j*S by (2^(BIT+1)*j + 2^(2*BIT))*S,
    // where t holds j*S; the bit stays if the residual can pay for it.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            delta[k] = (DLW'(t_in[k]) << (BIT + 1)) + (DLW'(sum_in) << (2 * BIT));
            take[k]  = (delta[k] <= DLW'(e_in[k]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg   <= sum_in;
            neg_reg   <= neg_in;
            degen_reg <= ctl_in.degen;
            for (int k = 0; k < 3; k++) begin
                e_reg[k] <= take[k] ? (e_in[k] - delta[k][EW-1:0]) : e_in[k];
                t_reg[k] <= take[k] ? (t_in[k] + (TW'(sum_in) << BIT)) : t_in[k];
                j_reg[k] <= j_in[k] | (JW'(take[k]) << BIT);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctl_in.valid;
        end
    end

    assign ctl_out.valid = valid_reg;
    assign ctl_out.degen = degen_reg;
    assign sum_out = sum_reg;
    assign neg_out = neg_reg;
    assign e_out   = e_reg;
    assign t_out   = t_reg;
    assign j_out   = j_reg;

endmodule

FILE: rtl/core/triangle_face_normal_unit.sv
// Channel   Dir  Beat contents (lowest bits first)
// s_axis    in   a_x a_y a_z b_x b_y b_z c_x c_y c_z, COORD_WIDTH bits each
// m_axis    out  tdata: normal_x normal_y normal_z (16 bits each); tuser: degenerate
//
// One beat enters per cycle while m_axis is not stalled, and its result passes
// through the cross-product stages, the squared-length stages, a square-root
// divide chain step for each result bit, and the output register. The reset is
// synchronous and active low and only clears the valid bits. A stall on m_axis
// freezes every stage at once; nothing is lost.
module triangle_face_normal_unit #(
    parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, then zero padding
    input  logic [((tfn_pkg::NUM_VERTS*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // normal_x, normal_y, normal_z
    output logic [3*tfn_pkg::OUT_W-1:0]                   m_tdata,
    // degenerate
    output logic                                          m_tuser
);

    localparam int NW    = 2 * COORD_WIDTH + 3;
    localparam int SQW   = 2 * NW;
    localparam int SUMW  = SQW + 2;
    localparam int EW    = SUMW + 2 * NORMAL_FRAC_BITS + 2;
    localparam int TW    = SUMW + NORMAL_FRAC_BITS + 2;
    localparam int JW    = NORMAL_FRAC_BITS + 2;
    localparam int NSTEP = NORMAL_FRAC_BITS + 2;
    localparam int OW    = tfn_pkg::OUT_W;
    localparam int VW    = JW + OW;

    logic en;
    logic [tfn_pkg::NUM_VERTS-1:0][COORD_WIDTH-1:0] coord;
    logic                cross_valid;
    logic [2:0][NW-1:0]  n_vec;
    logic                sq_valid;
    logic [2:0]          sq_neg;
    logic [2:0][SQW-1:0] sq_vec;
    logic [SUMW-1:0]     sq_sum;

    // Stage signals of the root chain; entry g feeds the step that decides
    // bit NORMAL_FRAC_BITS + 1 - g of j.
    tfn_pkg::tfn_ctl_t   ctl_s [NSTEP+1];
    logic [SUMW-1:0]     sum_s [NSTEP+1];
    logic [2:0]          neg_s [NSTEP+1];
    logic [2:0][EW-1:0]  e_s   [NSTEP+1];
    logic [2:0][TW-1:0]  t_s   [NSTEP+1];
    logic [2:0][JW-1:0]  j_s   [NSTEP+1];

    logic                m_tvalid_reg;
    logic [3*OW-1:0]     m_tdata_reg;
    logic                m_tuser_reg;
    logic [3*OW-1:0]     m_tdata_next;
    logic [JW:0]         j_inc;
    logic [VW-1:0]       k_val;
    logic [VW-1:0]       s_val;

    // The whole pipeline moves together whenever the output register is free
    // or is being emptied this cycle.
    assign en       = ~m_tvalid_reg | m_tready;
    assign s_tready = en;

    always_comb begin
        for (int i = 0; i < tfn_pkg::NUM_VERTS; i++) begin
            coord[i] = s_tdata[i*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    tfn_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .coord     (coord),
        .out_valid (cross_valid),
        .n_out     (n_vec)
    );

    tfn_norm_sq #(.COORD_WIDTH(COORD_WIDTH)) u_norm_sq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cross_valid),
        .n_in      (n_vec),
        .out_valid (sq_valid),
        .neg_out   (sq_neg),
        .sq_out    (sq_vec),
        .sum_out   (sq_sum)
    );

    // The root chain finds, per axis, the largest j with j*j*S <= sq*2^(2F+2),
    // that is j = floor(2^(F+1)*|n|/|n_total|). The residual starts at the
    // scaled square and j and j*S start at zero.
    always_comb begin
        ctl_s[0].valid = sq_valid;
        ctl_s[0].degen = (sq_sum == '0);
        sum_s[0]       = sq_sum;
        neg_s[0]       = sq_neg;
        for (int k = 0; k < 3; k++) begin
            e_s[0][k] = EW'(sq_vec[k]) << (2 * NORMAL_FRAC_BITS + 2);
            t_s[0][k] = '0;
            j_s[0][k] = '0;
        end
    end

    for (genvar g = 0; g < NSTEP; g++) begin : g_root
        tfn_digit #(
            .COORD_WIDTH      (COORD_WIDTH),
            .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
            .BIT              (NORMAL_FRAC_BITS + 1 - g)
        ) u_digit (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (ctl_s[g]),
            .sum_in  (sum_s[g]),
            .neg_in  (neg_s[g]),
            .e_in    (e_s[g]),
            .t_in    (t_s[g]),
            .j_in    (j_s[g]),
            .ctl_out (ctl_s[g+1]),
            .sum_out (sum_s[g+1]),
            .neg_out (neg_s[g+1]),
            .e_out   (e_s[g+1]),
            .t_out   (t_s[g+1]),
            .j_out   (j_s[g+1])
        );
    end

    // Rounding to nearest with ties away from zero picks k = (j + 1) / 2, since
    // the largest odd m <= j is the 2k - 1 that bounds the tie point. The sign
    // comes back from n and the degenerate case forces the zero vector.
    always_comb begin
        m_tdata_next = '0;
        j_inc        = '0;
        k_val        = '0;
        s_val        = '0;
        for (int k = 0; k < 3; k++) begin
            j_inc = {1'b0, j_s[NSTEP][k]} + 1'b1;
            k_val = VW'(j_inc[JW:1]);
            s_val = neg_s[NSTEP][k] ? (~k_val + 1'b1) : k_val;
            m_tdata_next[k*OW +: OW] = ctl_s[NSTEP].degen ? '0 : s_val[OW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= ctl_s[NSTEP].degen;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= ctl_s[NSTEP].valid;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
